>>> rtl/nph_pkg.sv
package nph_pkg;

   // Fixed field widths of the channels and registers.
   localparam int SIZE_WIDTH        = 9;
   localparam int TOL_WIDTH         = 8;
   localparam int CHAN_WIDTH        = 8;
   localparam int INDEX_WIDTH       = 8;
   localparam int WEIGHT_WIDTH      = 31;
   localparam int DIST_WIDTH        = 18;
   localparam int COLOR_WIDTH       = 24;
   localparam int SHOWN_COUNT_WIDTH = 32;
   localparam int ENTRY_WIDTH       = COLOR_WIDTH + 1;
   localparam int CSR_INDEX_WIDTH   = 1;
   localparam int CSR_DATA_WIDTH    = 9;

   // Reset value of the gray tolerance register.
   localparam logic [TOL_WIDTH-1:0] GRAY_TOL_RESET = 8'd5;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PALETTE_SIZE   = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GRAY_TOLERANCE = 1'd1;

   // Operation codes of an input beat.
   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_PIXEL = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Absolute difference of two channel values.
   function automatic logic [CHAN_WIDTH-1:0] absdiff8(input logic [CHAN_WIDTH-1:0] a,
                                                     input logic [CHAN_WIDTH-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // Count as shown on the result channel: saturated to 32 bits.
   function automatic logic [SHOWN_COUNT_WIDTH-1:0] show_count(input logic [63:0] c);
      return (|c[63:SHOWN_COUNT_WIDTH]) ? '1 : c[SHOWN_COUNT_WIDTH-1:0];
   endfunction

endpackage

>>> rtl/nearest_palette_histogram_unit.sv
// Nearest-palette color histogram.
// The req_ channel takes one beat per operation: load a palette entry (its
// counter is cleared), classify a weighted pixel, read an entry back or idle.
// The rsp_ channel returns exactly one beat for every accepted req_ beat,
// in order. The csr_ port writes the palette size and the gray tolerance
// and must only be used while no request is in flight.
// A pixel scan reads the palette memory one entry per cycle, followed by
// a read-modify-write of the hit counter memory when an entry of the
// pixel's class exists. One request is processed at a time; req_ready is
// high only while the sequencer is idle, even if a result is still
// waiting. A stalled receiver holds the finished result in the output
// register and the next result waits in the sequencer until that register
// drains. Reset clears the sequencer, the output valid and the registers
// (size 0, tolerance 5); the palette and counter memories are left
// unwritten.
module nearest_palette_histogram_unit
   import nph_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256,
   parameter int COUNT_WIDTH   = 32
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_operation,
   input  logic [INDEX_WIDTH-1:0]       req_entry_index,
   input  logic [CHAN_WIDTH-1:0]        req_red,
   input  logic [CHAN_WIDTH-1:0]        req_green,
   input  logic [CHAN_WIDTH-1:0]        req_blue,
   input  logic [WEIGHT_WIDTH-1:0]      req_weight,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_matched,
   output logic [INDEX_WIDTH-1:0]       rsp_match_index,
   output logic [DIST_WIDTH-1:0]        rsp_match_distance,
   output logic [COLOR_WIDTH-1:0]       rsp_entry_color,
   output logic [SHOWN_COUNT_WIDTH-1:0] rsp_entry_count,
   input  logic                         csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]    csr_data
);

   localparam int AW      = $clog2(PALETTE_DEPTH);
   localparam int SUMW    = ((COUNT_WIDTH > WEIGHT_WIDTH) ? COUNT_WIDTH : WEIGHT_WIDTH) + 1;
   localparam logic [31:0] DEPTH32 = 32'(PALETTE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CNT_RD,
      ST_CNT_ADD,
      ST_RD_WAIT,
      ST_FIN
   } state_type;

   state_type                   state_ff, state_in;
   logic [SIZE_WIDTH-1:0]       size_ff, size_in;
   logic [TOL_WIDTH-1:0]        tol_ff, tol_in;
   logic [INDEX_WIDTH-1:0]      idx_ff, idx_in;
   logic [CHAN_WIDTH-1:0]       r_ff, r_in, g_ff, g_in, b_ff, b_in;
   logic [WEIGHT_WIDTH-1:0]     w_ff, w_in;
   logic                        pgray_ff, pgray_in;
   logic [SIZE_WIDTH-1:0]       n_ff, n_in;
   logic [SIZE_WIDTH-1:0]       scan_ff, scan_in;
   logic                        found_ff, found_in;
   logic [SIZE_WIDTH-1:0]       best_ff, best_in;
   logic [DIST_WIDTH-1:0]       bestd_ff, bestd_in;
   logic [COLOR_WIDTH-1:0]      bestc_ff, bestc_in;
   logic                        res_matched_ff, res_matched_in;
   logic [INDEX_WIDTH-1:0]      res_index_ff, res_index_in;
   logic [DIST_WIDTH-1:0]       res_dist_ff, res_dist_in;
   logic [COLOR_WIDTH-1:0]      res_color_ff, res_color_in;
   logic [SHOWN_COUNT_WIDTH-1:0] res_count_ff, res_count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_matched_ff, rsp_matched_in;
   logic [INDEX_WIDTH-1:0]      rsp_index_ff, rsp_index_in;
   logic [DIST_WIDTH-1:0]       rsp_dist_ff, rsp_dist_in;
   logic [COLOR_WIDTH-1:0]      rsp_color_ff, rsp_color_in;
   logic [SHOWN_COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   // Memory port signals.
   logic                        pal_we, cnt_we;
   logic [AW-1:0]               wr_addr, rd_addr;
   logic [ENTRY_WIDTH-1:0]      pal_wdata, pal_q;
   logic [COUNT_WIDTH-1:0]      cnt_wdata, cnt_q;

   // Datapath helpers.
   logic                        accept;
   logic [SIZE_WIDTH-1:0]       n_now;
   logic                        pix_gray;
   logic [CHAN_WIDTH-1:0]       dr, dg, db;
   logic [DIST_WIDTH-1:0]       entry_dist;
   logic [SUMW-1:0]             sum;
   logic [COUNT_WIDTH-1:0]      new_count;

   nph_ram #(.WIDTH(ENTRY_WIDTH), .DEPTH(PALETTE_DEPTH)) u_palette (
      .clock         (clock),
      .write_enable  (pal_we),
      .write_address (wr_addr),
      .write_data    (pal_wdata),
      .read_address  (rd_addr),
      .read_data     (pal_q)
   );

   nph_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(PALETTE_DEPTH)) u_counts (
      .clock         (clock),
      .write_enable  (cnt_we),
      .write_address (wr_addr),
      .write_data    (cnt_wdata),
      .read_address  (rd_addr),
      .read_data     (cnt_q)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Palette size in use, capped at the memory depth.
   assign n_now = (32'(size_ff) < DEPTH32) ? size_ff : SIZE_WIDTH'(PALETTE_DEPTH);

   // Gray class of the incoming pixel.
   assign pix_gray = (absdiff8(req_red, req_green) <= tol_ff) &&
                     (absdiff8(req_red, req_blue) <= tol_ff) &&
                     (absdiff8(req_green, req_blue) <= tol_ff);

   // Squared distance between the held pixel and the entry read this cycle.
   assign dr   = absdiff8(r_ff, pal_q[23:16]);
   assign dg   = absdiff8(g_ff, pal_q[15:8]);
   assign db   = absdiff8(b_ff, pal_q[7:0]);
   assign entry_dist = DIST_WIDTH'(16'(dr) * 16'(dr)) + DIST_WIDTH'(16'(dg) * 16'(dg)) +
                       DIST_WIDTH'(16'(db) * 16'(db));

   // Saturating counter update.
   assign sum       = SUMW'(cnt_q) + SUMW'(w_ff);
   assign new_count = (|sum[SUMW-1:COUNT_WIDTH]) ? '1 : sum[COUNT_WIDTH-1:0];

   // Sequencer and next-state logic.
   always_comb begin
      state_in       = state_ff;
      size_in        = size_ff;
      tol_in         = tol_ff;
      idx_in         = idx_ff;
      r_in           = r_ff;
      g_in           = g_ff;
      b_in           = b_ff;
      w_in           = w_ff;
      pgray_in       = pgray_ff;
      n_in           = n_ff;
      scan_in        = scan_ff;
      found_in       = found_ff;
      best_in        = best_ff;
      bestd_in       = bestd_ff;
      bestc_in       = bestc_ff;
      res_matched_in = res_matched_ff;
      res_index_in   = res_index_ff;
      res_dist_in    = res_dist_ff;
      res_color_in   = res_color_ff;
      res_count_in   = res_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_matched_in = rsp_matched_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_color_in   = rsp_color_ff;
      rsp_count_in   = rsp_count_ff;
      pal_we         = 1'b0;
      cnt_we         = 1'b0;
      wr_addr        = AW'(req_entry_index);
      pal_wdata      = {(req_red == req_green) && (req_red == req_blue),
                        req_red, req_green, req_blue};
      cnt_wdata      = '0;
      rd_addr        = AW'(idx_ff);

      // Configuration writes.
      if (csr_write) begin
         case (csr_index)
            REG_PALETTE_SIZE: begin
               size_in = csr_data[SIZE_WIDTH-1:0];
            end
            REG_GRAY_TOLERANCE: begin
               tol_in = csr_data[TOL_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in         = req_entry_index;
               r_in           = req_red;
               g_in           = req_green;
               b_in           = req_blue;
               w_in           = req_weight;
               pgray_in       = pix_gray;
               n_in           = n_now;
               scan_in        = '0;
               found_in       = 1'b0;
               res_matched_in = 1'b0;
               res_index_in   = '0;
               res_dist_in    = '0;
               res_color_in   = '0;
               res_count_in   = '0;
               state_in       = ST_FIN;
               case (op_type'(req_operation))
                  OP_LOAD: begin
                     res_index_in = req_entry_index;
                     if (32'(req_entry_index) < DEPTH32) begin
                        pal_we         = 1'b1;
                        cnt_we         = 1'b1;
                        res_matched_in = 1'b1;
                        res_color_in   = {req_red, req_green, req_blue};
                     end
                  end
                  OP_PIXEL: begin
                     rd_addr = '0;
                     if (n_now != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_READ: begin
                     res_index_in = req_entry_index;
                     rd_addr      = AW'(req_entry_index);
                     if ({1'b0, req_entry_index} < n_now) begin
                        state_in = ST_RD_WAIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // Entry scan_ff arrives; the next one is requested.
            rd_addr = AW'(scan_ff + 1'b1);
            if ((pal_q[COLOR_WIDTH] == pgray_ff) &&
                (!found_ff || (entry_dist < bestd_ff))) begin
               found_in = 1'b1;
               best_in  = scan_ff;
               bestd_in = entry_dist;
               bestc_in = pal_q[COLOR_WIDTH-1:0];
            end
            if (scan_ff == n_ff - 1'b1) begin
               state_in = ST_CNT_RD;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         ST_CNT_RD: begin
            rd_addr = AW'(best_ff);
            if (found_ff) begin
               state_in = ST_CNT_ADD;
            end else begin
               state_in = ST_FIN;
            end
         end

         ST_CNT_ADD: begin
            cnt_we         = 1'b1;
            wr_addr        = AW'(best_ff);
            cnt_wdata      = new_count;
            res_matched_in = 1'b1;
            res_index_in   = best_ff[INDEX_WIDTH-1:0];
            res_dist_in    = bestd_ff;
            res_color_in   = bestc_ff;
            res_count_in   = show_count(64'(new_count));
            state_in       = ST_FIN;
         end

         ST_RD_WAIT: begin
            res_matched_in = 1'b1;
            res_color_in   = pal_q[COLOR_WIDTH-1:0];
            res_count_in   = show_count(64'(cnt_q));
            state_in       = ST_FIN;
         end

         ST_FIN: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_matched_in = res_matched_ff;
               rsp_index_in   = res_index_ff;
               rsp_dist_in    = res_dist_ff;
               rsp_color_in   = res_color_ff;
               rsp_count_in   = res_count_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= '0;
         tol_ff       <= GRAY_TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      r_ff           <= r_in;
      g_ff           <= g_in;
      b_ff           <= b_in;
      w_ff           <= w_in;
      pgray_ff       <= pgray_in;
      n_ff           <= n_in;
      scan_ff        <= scan_in;
      found_ff       <= found_in;
      best_ff        <= best_in;
      bestd_ff       <= bestd_in;
      bestc_ff       <= bestc_in;
      res_matched_ff <= res_matched_in;
      res_index_ff   <= res_index_in;
      res_dist_ff    <= res_dist_in;
      res_color_ff   <= res_color_in;
      res_count_ff   <= res_count_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_color_ff   <= rsp_color_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_matched        = rsp_matched_ff;
   assign rsp_match_index    = rsp_index_ff;
   assign rsp_match_distance = rsp_dist_ff;
   assign rsp_entry_color    = rsp_color_ff;
   assign rsp_entry_count    = rsp_count_ff;

   // The scan never runs past the palette size in use.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff < n_ff))
      else $error("scan index beyond palette size");

   // A counter is only updated when a same-class entry was found.
   a_update_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CNT_ADD) |-> found_ff)
      else $error("counter update without a match");

   // A new result is only raised from the finishing step.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ready)) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside the finishing step");

endmodule

>>> rtl/nph_ram.sv
module nph_ram
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
)
(
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

>>> dv/nearest_palette_histogram_unit_tb.sv
`timescale 1ns / 1ps

module nearest_palette_histogram_unit_tb;
   import nph_pkg::*;

   localparam int NUM_ENTRIES  = 256;
   localparam int MAX_GAP      = 18;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 300;
   localparam logic [SHOWN_COUNT_WIDTH-1:0] COUNT_FULL = '1;

   // Register settings of the random phases; sizes above the depth clamp to it.
   localparam int NUM_PHASES = 12;
   localparam int PHASE_SIZE  [NUM_PHASES] = '{1, 2, 3, 7, 16, 256, 0, 33, 511, 12, 100, 4};
   localparam int PHASE_TOL   [NUM_PHASES] = '{0, 5, 255, 3, 20, 10, 7, 255, 1, 40, 0, 12};
   localparam int PHASE_ITEMS [NUM_PHASES] = '{100, 100, 100, 110, 110, 40, 30, 110, 40, 110,
                                              70, 150};
   localparam int HOLD_PHASE = 3;

   typedef struct packed {
      logic [1:0]              op;
      logic [INDEX_WIDTH-1:0]  index;
      logic [CHAN_WIDTH-1:0]   red;
      logic [CHAN_WIDTH-1:0]   green;
      logic [CHAN_WIDTH-1:0]   blue;
      logic [WEIGHT_WIDTH-1:0] weight;
   } hist_req_type;

   typedef struct packed {
      logic                         matched;
      logic [INDEX_WIDTH-1:0]       index;
      logic [DIST_WIDTH-1:0]        distance;
      logic [COLOR_WIDTH-1:0]       color;
      logic [SHOWN_COUNT_WIDTH-1:0] count;
   } hist_rsp_type;

   // One line of the directed table: either a register write or a request beat,
   // the latter with an optional result that is known by inspection.
   typedef struct {
      logic                       is_csr;
      logic [CSR_INDEX_WIDTH-1:0] reg_index;
      logic [CSR_DATA_WIDTH-1:0]  reg_value;
      hist_req_type               req;
      logic                       has_exp;
      hist_rsp_type               exp;
   } stim_row_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic [1:0]                   req_operation;
   logic [INDEX_WIDTH-1:0]       req_entry_index;
   logic [CHAN_WIDTH-1:0]        req_red;
   logic [CHAN_WIDTH-1:0]        req_green;
   logic [CHAN_WIDTH-1:0]        req_blue;
   logic [WEIGHT_WIDTH-1:0]      req_weight;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic                         rsp_matched;
   logic [INDEX_WIDTH-1:0]       rsp_match_index;
   logic [DIST_WIDTH-1:0]        rsp_match_distance;
   logic [COLOR_WIDTH-1:0]       rsp_entry_color;
   logic [SHOWN_COUNT_WIDTH-1:0] rsp_entry_count;
   logic                         csr_write;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index;
   logic [CSR_DATA_WIDTH-1:0]    csr_data;

   // Shadow copy of the palette, hit counters and registers.
   logic [ENTRY_WIDTH-1:0]       palette_q [NUM_ENTRIES];
   logic [SHOWN_COUNT_WIDTH-1:0] hits_q [NUM_ENTRIES];
   logic [SIZE_WIDTH-1:0]        size_q;
   logic [TOL_WIDTH-1:0]         tol_q;

   // Results still owed by the block, oldest first.
   hist_rsp_type awaited_beats [$];

   // Directed table, walked in order.
   stim_row_type directed_rows [$];

   bit send_idle   = 1'b1;
   bit recv_idle   = 1'b1;
   int hold_cycles = 0;

   int error_count = 0;
   int n_checked   = 0;
   int n_loads     = 0;
   int n_pixels    = 0;
   int n_reads     = 0;
   int n_noops     = 0;
   int n_dropped   = 0;
   int n_saturated = 0;
   int n_settings  = 0;
   int n_holds     = 0;

   nearest_palette_histogram_unit dut (.*);

   // Free-running clock, 8 ns period.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic int chan_gap(logic [CHAN_WIDTH-1:0] a, logic [CHAN_WIDTH-1:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
   endfunction

   function automatic int entries_in_use();
      return (size_q > NUM_ENTRIES) ? NUM_ENTRIES : int'(size_q);
   endfunction

   // Applies one request beat to the shadow state and returns the result it owes.
   function automatic hist_rsp_type quantize_step(hist_req_type r);
      hist_rsp_type                 o;
      logic [COLOR_WIDTH-1:0]       col;
      logic [COLOR_WIDTH-1:0]       ent;
      logic                         gray;
      logic [SHOWN_COUNT_WIDTH:0]   sum;
      int                           n;
      int                           best;
      int                           best_d;
      int                           d;
      int                           dr;
      int                           dg;
      int                           db;
      o = '0;
      n = entries_in_use();
      col = {r.red, r.green, r.blue};
      case (r.op)
         OP_LOAD: begin
            gray = (r.red == r.green) && (r.red == r.blue);
            palette_q[r.index] = {gray, col};
            hits_q[r.index] = '0;
            o.matched = 1'b1;
            o.index = r.index;
            o.color = col;
            n_loads++;
         end
         OP_PIXEL: begin
            gray = (chan_gap(r.red, r.green) <= int'(tol_q)) &&
                   (chan_gap(r.red, r.blue) <= int'(tol_q)) &&
                   (chan_gap(r.green, r.blue) <= int'(tol_q));
            best = -1;
            best_d = 0;
            // Scan from index zero; a strict compare keeps the lowest index on a tie.
            for (int j = 0; j < n; j++) begin
               if (palette_q[j][COLOR_WIDTH] != gray) continue;
               ent = palette_q[j][COLOR_WIDTH-1:0];
               dr = chan_gap(r.red, ent[23:16]);
               dg = chan_gap(r.green, ent[15:8]);
               db = chan_gap(r.blue, ent[7:0]);
               d = dr * dr + dg * dg + db * db;
               if (best < 0 || d < best_d) begin
                  best = j;
                  best_d = d;
               end
            end
            n_pixels++;
            if (best < 0) begin
               n_dropped++;
            end else begin
               sum = {1'b0, hits_q[best]} + r.weight;
               if (sum[SHOWN_COUNT_WIDTH]) begin
                  sum = '1;
                  n_saturated++;
               end
               hits_q[best] = sum[SHOWN_COUNT_WIDTH-1:0];
               o.matched = 1'b1;
               o.index = INDEX_WIDTH'(best);
               o.distance = DIST_WIDTH'(best_d);
               o.color = palette_q[best][COLOR_WIDTH-1:0];
               o.count = hits_q[best];
            end
         end
         OP_READ: begin
            o.index = r.index;
            if (int'(r.index) < n) begin
               o.matched = 1'b1;
               o.color = palette_q[r.index][COLOR_WIDTH-1:0];
               o.count = hits_q[r.index];
            end
            n_reads++;
         end
         default: begin
            n_noops++;
         end
      endcase
      return o;
   endfunction

   function automatic logic [CHAN_WIDTH-1:0] clip8(int v);
      return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
   endfunction

   function automatic hist_req_type random_fields();
      hist_req_type r;
      r.op = 2'($urandom);
      r.index = 8'($urandom);
      r.red = 8'($urandom);
      r.green = 8'($urandom);
      r.blue = 8'($urandom);
      r.weight = 31'($urandom);
      return r;
   endfunction

   // Mostly small weights, with full-scale ones often enough to saturate counters.
   function automatic logic [WEIGHT_WIDTH-1:0] draw_weight();
      case ($urandom_range(0, 19))
         0, 1:    return '1;
         2, 3, 4: return 31'($urandom);
         5:       return '0;
         default: return 31'($urandom_range(1, 5000));
      endcase
   endfunction

   // Load beat: some gray entries, some duplicates of other entries to force ties.
   function automatic hist_req_type make_load(int idx);
      hist_req_type r;
      int           pick;
      r = random_fields();
      r.op = OP_LOAD;
      r.index = 8'(idx);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         r.green = r.red;
         r.blue = r.red;
      end else if (pick < 45) begin
         {r.red, r.green, r.blue} = palette_q[$urandom_range(0, NUM_ENTRIES - 1)][23:0];
      end
      return r;
   endfunction

   // Pixel beat: near a palette entry, near the gray tolerance edge, or anywhere.
   function automatic hist_req_type make_pixel();
      hist_req_type           r;
      logic [COLOR_WIDTH-1:0] base;
      int                     n;
      int                     mode;
      int                     v;
      int                     t;
      r = random_fields();
      r.op = OP_PIXEL;
      r.weight = draw_weight();
      n = entries_in_use();
      mode = $urandom_range(0, 9);
      if (n > 0 && mode < 4) begin
         base = palette_q[$urandom_range(0, n - 1)][COLOR_WIDTH-1:0];
         r.red = clip8(int'(base[23:16]) + int'($urandom_range(0, 6)) - 3);
         r.green = clip8(int'(base[15:8]) + int'($urandom_range(0, 6)) - 3);
         r.blue = clip8(int'(base[7:0]) + int'($urandom_range(0, 6)) - 3);
      end else if (mode < 7) begin
         v = $urandom_range(0, 255);
         t = int'(tol_q) + 1;
         r.red = clip8(v + int'($urandom_range(0, t)));
         r.green = clip8(v + int'($urandom_range(0, t)));
         r.blue = clip8(v + int'($urandom_range(0, t)));
      end
      return r;
   endfunction

   // Random mix of operations for the phases after the palette is filled.
   function automatic hist_req_type make_item();
      hist_req_type r;
      int           pick;
      int           n;
      pick = $urandom_range(0, 99);
      n = entries_in_use();
      if (pick < 15) begin
         r = make_load($urandom_range(0, NUM_ENTRIES - 1));
      end else if (pick < 75) begin
         r = make_pixel();
      end else if (pick < 93) begin
         r = random_fields();
         r.op = OP_READ;
         if (n > 0 && $urandom_range(0, 2) != 0) r.index = 8'($urandom_range(0, n - 1));
      end else begin
         r = random_fields();
         r.op = OP_NONE;
      end
      return r;
   endfunction

   function automatic stim_row_type req_row(op_type op, int idx, int red, int green, int blue,
                                            logic [WEIGHT_WIDTH-1:0] w);
      stim_row_type row;
      row = '{default: '0};
      row.req.op = op;
      row.req.index = 8'(idx);
      row.req.red = 8'(red);
      row.req.green = 8'(green);
      row.req.blue = 8'(blue);
      row.req.weight = w;
      return row;
   endfunction

   // Known results of the table never carry a nonzero distance.
   function automatic stim_row_type known_row(stim_row_type row, logic m, int idx,
                                              logic [COLOR_WIDTH-1:0] col,
                                              logic [SHOWN_COUNT_WIDTH-1:0] cnt);
      row.has_exp = 1'b1;
      row.exp.matched = m;
      row.exp.index = 8'(idx);
      row.exp.distance = '0;
      row.exp.color = col;
      row.exp.count = cnt;
      return row;
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_INDEX_WIDTH-1:0] idx, int value);
      stim_row_type row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.reg_index = idx;
      row.reg_value = 9'(value);
      return row;
   endfunction

   // Appends one line to the directed table.
   function automatic void add_row(stim_row_type row);
      directed_rows = {directed_rows, row};
   endfunction

   // Offers one request beat, after a random gap when send_idle is set; entered and left at a falling edge.
   task automatic offer_beat(hist_req_type r, logic has_known, hist_rsp_type known);
      int           gap;
      hist_rsp_type pred;
      gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = r.op;
      req_entry_index = r.index;
      req_red = r.red;
      req_green = r.green;
      req_blue = r.blue;
      req_weight = r.weight;
      do @(posedge clock); while (!req_ready);
      pred = quantize_step(r);
      if (has_known) pred = known;
      awaited_beats = {awaited_beats, pred};
      @(negedge clock);
   endtask

   // Register write, issued at a falling edge while the block is idle.
   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] idx,
                                 logic [CSR_DATA_WIDTH-1:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      if (idx == REG_PALETTE_SIZE) size_q = value;
      else tol_q = value[TOL_WIDTH-1:0];
      n_settings++;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   // Stops offering beats and waits until every owed result has come back.
   task automatic settle();
      req_valid = 1'b0;
      while (awaited_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic check_beat(hist_rsp_type got);
      hist_rsp_type want;
      if (awaited_beats.size() == 0) begin
         $error("result beat with nothing outstanding, index %0d", got.index);
         error_count++;
         return;
      end
      want = awaited_beats.pop_front();
      n_checked++;
      if (got.matched !== want.matched) begin
         $error("matched mismatch: expected %0h, got %0h", want.matched, got.matched);
         error_count++;
      end
      if (got.index !== want.index) begin
         $error("match_index mismatch: expected %0h, got %0h", want.index, got.index);
         error_count++;
      end
      if (got.distance !== want.distance) begin
         $error("match_distance mismatch: expected %0h, got %0h", want.distance,
                got.distance);
         error_count++;
      end
      if (got.color !== want.color) begin
         $error("entry_color mismatch: expected %0h, got %0h", want.color, got.color);
         error_count++;
      end
      if (got.count !== want.count) begin
         $error("entry_count mismatch: expected %0h, got %0h", want.count, got.count);
         error_count++;
      end
   endtask

   // Result side: random stalls per beat when recv_idle is set, plus one long hold-off on request.
   initial begin : result_sink
      int           stall;
      hist_rsp_type got;
      rsp_ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
         if (hold_cycles > 0) begin
            stall = hold_cycles;
            hold_cycles = 0;
            n_holds++;
         end
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got = {rsp_matched, rsp_match_index, rsp_match_distance, rsp_entry_color,
                rsp_entry_count};
         check_beat(got);
         @(negedge clock);
      end
   end

   // Request side: directed table, palette fill, then random phases.
   initial begin : stimulus
      req_valid = 1'b0;
      req_operation = '0;
      req_entry_index = '0;
      req_red = '0;
      req_green = '0;
      req_blue = '0;
      req_weight = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      reset = 1'b1;
      size_q = '0;
      tol_q = GRAY_TOL_RESET;
      foreach (palette_q[k]) begin
         palette_q[k] = '0;
         hits_q[k] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty palette after reset, idle op, then loads at the index extremes.
      add_row(known_row(req_row(OP_READ, 0, 0, 0, 0, 0), 0, 0, 0, 0));
      add_row(known_row(req_row(OP_PIXEL, 0, 'h10, 'h20, 'h30, 7), 0, 0, 0, 0));
      add_row(known_row(req_row(OP_NONE, 255, 255, 255, 255, '1), 0, 0, 0, 0));
      add_row(known_row(req_row(OP_LOAD, 0, 0, 0, 0, 0), 1, 0, 24'h000000, 0));
      add_row(known_row(req_row(OP_LOAD, 1, 255, 255, 255, '1), 1, 1, 24'hffffff, 0));
      add_row(known_row(req_row(OP_LOAD, 2, 255, 0, 0, 0), 1, 2, 24'hff0000, 0));
      add_row(known_row(req_row(OP_LOAD, 3, 0, 255, 255, 0), 1, 3, 24'h00ffff, 0));
      add_row(known_row(req_row(OP_LOAD, 255, 'h12, 'h34, 'h56, 0), 1, 255, 24'h123456, 0));
      add_row(csr_row(REG_PALETTE_SIZE, 4));
      add_row(csr_row(REG_GRAY_TOLERANCE, 0));
      // Full-scale weights drive the counter of entry 2 into saturation.
      add_row(known_row(req_row(OP_PIXEL, 9, 255, 0, 0, '1),
                        1, 2, 24'hff0000, 32'h7fffffff));
      add_row(known_row(req_row(OP_PIXEL, 0, 255, 0, 0, '1),
                        1, 2, 24'hff0000, 32'hfffffffe));
      add_row(known_row(req_row(OP_PIXEL, 0, 255, 0, 0, '1),
                        1, 2, 24'hff0000, COUNT_FULL));
      add_row(req_row(OP_PIXEL, 0, 0, 0, 1, 0));
      add_row(req_row(OP_PIXEL, 0, 'h80, 'h80, 'h80, 1));
      // Entries 2 and 3 end up equally far from the next pixel.
      add_row(known_row(req_row(OP_LOAD, 3, 0, 0, 255, 0), 1, 3, 24'h0000ff, 0));
      add_row(req_row(OP_PIXEL, 0, 255, 0, 255, 3));
      add_row(csr_row(REG_GRAY_TOLERANCE, 255));
      add_row(req_row(OP_PIXEL, 0, 255, 0, 0, 5));
      add_row(req_row(OP_READ, 2, 0, 0, 0, 0));
      add_row(known_row(req_row(OP_READ, 4, 0, 0, 0, 0), 0, 4, 0, 0));
      add_row(known_row(req_row(OP_READ, 255, 255, 255, 255, '1), 0, 255, 0, 0));
      add_row(req_row(OP_PIXEL, 77, 'h7f, 'h80, 'h7e, 31'h2aaaaaaa));

      foreach (directed_rows[k]) begin
         if (directed_rows[k].is_csr) begin
            settle();
            write_register(directed_rows[k].reg_index, directed_rows[k].reg_value);
         end else begin
            offer_beat(directed_rows[k].req, directed_rows[k].has_exp, directed_rows[k].exp);
         end
      end

      // Every slot is loaded once so that any later size only scans written entries.
      for (int k = 0; k < NUM_ENTRIES; k++) offer_beat(make_load(k), 1'b0, '0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         write_register(REG_PALETTE_SIZE, 9'(PHASE_SIZE[p]));
         write_register(REG_GRAY_TOLERANCE, {1'($urandom), 8'(PHASE_TOL[p])});
         send_idle = (p % 3) != 1;
         recv_idle = (p % 4) != 2;
         if (p == HOLD_PHASE) hold_cycles = HOLD_CYCLES;
         repeat (PHASE_ITEMS[p]) offer_beat(make_item(), 1'b0, '0);
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d result beats: %0d loads, %0d pixels, %0d reads, %0d idle ops,",
               n_checked, n_loads, n_pixels, n_reads, n_noops);
      $display("%0d register writes, %0d pixels without a same-class entry, %0d saturations, %0d long stalls.",
               n_settings, n_dropped, n_saturated, n_holds);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      #20_000_000;
      $display("Timeout: the run did not finish in time.");
      $display("FAIL");
      $finish;
   end

endmodule

>>> nearest_palette_histogram_unit.f
rtl/nph_pkg.sv
rtl/nph_ram.sv
rtl/nearest_palette_histogram_unit.sv
dv/nearest_palette_histogram_unit_tb.sv
